// ===== src/hifs_pkg.sv =====
// Package for the held-input fault supervisor: word types, register
// indexes, reset values and the hold-count compare helper.
// No dependencies.
package hifs_pkg;

    // Width of every hold counter (8 to 32).
    localparam int COUNT_BITS = 16;
    // Width of the hold-count registers and of the temperature limit.
    localparam int HOLD_W = 16;
    localparam int TEMP_W = 8;
    localparam int CMP_W = (COUNT_BITS > HOLD_W) ? COUNT_BITS : HOLD_W;

    localparam int PIN_COUNT = 7;
    localparam int FAULT_PINS = 3;
    localparam int LATCH_W = 4;

    // Pin positions, in word order.
    localparam int PIN_ELEC = 0;
    localparam int PIN_LOW_PRESS = 1;
    localparam int PIN_HIGH_PRESS = 2;
    localparam int PIN_REMOTE_START = 3;
    localparam int PIN_REMOTE_STOP = 4;
    localparam int PIN_RUN_KEY = 5;
    localparam int PIN_SET_KEY = 6;

    localparam int LATCH_OVER_TEMP = 3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_HOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_HOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT = 3'd4;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd3000;
    localparam logic signed [TEMP_W-1:0] LIMIT_RESET = 8'sd28;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef struct packed {
        logic                     elec_fault_pin;
        logic                     low_press_pin;
        logic                     high_press_pin;
        logic                     remote_start_pin;
        logic                     remote_stop_pin;
        logic                     run_key_pin;
        logic                     set_key_lvl;
        logic signed [TEMP_W-1:0] temperature;
    } t_tick;

    typedef struct packed {
        logic elec_fault;
        logic low_press_fault;
        logic high_press_fault;
        logic over_temp_fault;
        logic relay_on;
        logic run_lamp_on;
        logic set_key_event;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [HOLD_W-1:0]    value;
    } t_cfg;

    // True when an incremented counter equals its hold count; a hold count
    // beyond the counter range never matches.
    function automatic logic hold_match(t_count cnt, logic [HOLD_W-1:0] hold);
        return CMP_W'(cnt) == CMP_W'(hold);
    endfunction

endpackage

// ===== src/hifs_if.sv =====
// Valid/ready channel interfaces for tick words, result words and
// configuration writes. Depends on hifs_pkg.
interface hifs_tick_if import hifs_pkg::*;;
    logic  valid;
    logic  ready;
    t_tick data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hifs_result_if import hifs_pkg::*;;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hifs_cfg_if import hifs_pkg::*;;
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/held_input_fault_supervisor.sv =====
// Held-input fault supervisor: top level, input stage, hold counters,
// fault latches, relay logic and output stage. Depends on hifs_pkg, hifs_if.
//
// Usage:
//   i_tick   - one word per timer tick: seven active-low pin levels and a
//              signed temperature. A word is taken on valid && ready.
//   o_result - exactly one word per tick: the four fault lamps, relay and
//              run lamp state after that tick, and the set-key pulse.
//   i_cfg    - register writes (index, value); always ready. Write only while
//              no tick is in flight.
// Path: a tick word is held in the input register, then goes through the single
//   update pass into the result register.
// Throughput: one word per cycle while o_result is not held off; all counters update
//   in parallel in the one pass between the input register and the result register.
// Reset (i_rst_n low, synchronous): counters, latches, relay and lamp clear,
//   registers return to 3000 ticks and a 28 degree limit, both stages empty.
// Stall: while o_result is held off the result word holds; the input register
//   still takes one more word, and i_tick.ready drops only when both are full.
module held_input_fault_supervisor import hifs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    hifs_tick_if.sink           i_tick,
    hifs_cfg_if.sink            i_cfg,
    hifs_result_if.source       o_result
);

    // Input stage
    logic  r_in_valid;
    t_tick r_in;
    // Output stage
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    // Configuration
    logic [HOLD_W-1:0]        r_fault_hold;
    logic [HOLD_W-1:0]        r_temp_hold;
    logic [HOLD_W-1:0]        r_remote_hold;
    logic [HOLD_W-1:0]        r_key_hold;
    logic signed [TEMP_W-1:0] r_temp_limit;

    // Supervisor state
    t_count               r_cnt [PIN_COUNT];
    t_count               n_cnt [PIN_COUNT];
    t_count               r_temp_cnt;
    t_count               n_temp_cnt;
    logic [LATCH_W-1:0]   r_latch;
    logic [LATCH_W-1:0]   n_latch;
    logic                 r_relay;
    logic                 n_relay;
    logic                 r_lamp;
    logic                 n_lamp;

    logic                 advance;
    logic [PIN_COUNT-1:0] pins;
    t_count               inc [PIN_COUNT];
    t_count               temp_inc;
    logic                 set_evt;

    // Move the input word on when the result register is free or being taken.
    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_tick.ready   = !r_in_valid || advance;
    assign i_cfg.ready    = 1'b1;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    assign pins = {r_in.set_key_lvl, r_in.run_key_pin, r_in.remote_stop_pin,
                   r_in.remote_start_pin, r_in.high_press_pin,
                   r_in.low_press_pin, r_in.elec_fault_pin};

    always_comb begin
        for (int i = 0; i < PIN_COUNT; i++) begin
            inc[i] = r_cnt[i] + 1'b1;
        end
        temp_inc = r_temp_cnt + 1'b1;
    end

    // One update pass, in tick order: faults, over-temperature, remote start,
    // remote stop, start/stop key, set key. Later actions see earlier ones.
    always_comb begin
        n_cnt      = r_cnt;
        n_temp_cnt = r_temp_cnt;
        n_latch    = r_latch;
        n_relay    = r_relay;
        n_lamp     = r_lamp;
        set_evt    = 1'b0;

        // Fault pins: a match on an already latched fault leaves the count running.
        for (int f = 0; f < FAULT_PINS; f++) begin
            if (pins[f]) begin
                n_cnt[f] = '0;
            end else begin
                n_cnt[f] = inc[f];
                if (hold_match(inc[f], r_fault_hold) && !r_latch[f]) begin
                    n_cnt[f]   = '0;
                    n_latch[f] = 1'b1;
                end
            end
        end

        // Over-temperature: hold the counter at zero once latched.
        if ((r_in.temperature > r_temp_limit) && !r_latch[LATCH_OVER_TEMP]) begin
            n_temp_cnt = temp_inc;
            if (hold_match(temp_inc, r_temp_hold)) begin
                n_temp_cnt               = '0;
                n_latch[LATCH_OVER_TEMP] = 1'b1;
            end
        end else begin
            n_temp_cnt = '0;
        end

        // Remote start, then remote stop: stop wins when both fire.
        if (pins[PIN_REMOTE_START]) begin
            n_cnt[PIN_REMOTE_START] = '0;
        end else if (hold_match(inc[PIN_REMOTE_START], r_remote_hold)) begin
            n_cnt[PIN_REMOTE_START] = '0;
            n_relay                 = 1'b1;
        end else begin
            n_cnt[PIN_REMOTE_START] = inc[PIN_REMOTE_START];
        end

        if (pins[PIN_REMOTE_STOP]) begin
            n_cnt[PIN_REMOTE_STOP] = '0;
        end else if (hold_match(inc[PIN_REMOTE_STOP], r_remote_hold)) begin
            n_cnt[PIN_REMOTE_STOP] = '0;
            n_relay                = 1'b0;
        end else begin
            n_cnt[PIN_REMOTE_STOP] = inc[PIN_REMOTE_STOP];
        end

        // Start/stop key: clear all faults, toggle relay and lamp last.
        if (pins[PIN_RUN_KEY]) begin
            n_cnt[PIN_RUN_KEY] = '0;
        end else if (hold_match(inc[PIN_RUN_KEY], r_key_hold)) begin
            n_cnt[PIN_RUN_KEY] = '0;
            n_latch            = '0;
            n_relay            = !n_relay;
            n_lamp             = !r_lamp;
        end else begin
            n_cnt[PIN_RUN_KEY] = inc[PIN_RUN_KEY];
        end

        // Set key: single-tick pulse.
        if (pins[PIN_SET_KEY]) begin
            n_cnt[PIN_SET_KEY] = '0;
        end else if (hold_match(inc[PIN_SET_KEY], r_key_hold)) begin
            n_cnt[PIN_SET_KEY] = '0;
            set_evt            = 1'b1;
        end else begin
            n_cnt[PIN_SET_KEY] = inc[PIN_SET_KEY];
        end

        n_out.elec_fault       = n_latch[PIN_ELEC];
        n_out.low_press_fault  = n_latch[PIN_LOW_PRESS];
        n_out.high_press_fault = n_latch[PIN_HIGH_PRESS];
        n_out.over_temp_fault  = n_latch[LATCH_OVER_TEMP];
        n_out.relay_on         = n_relay;
        n_out.run_lamp_on      = n_lamp;
        n_out.set_key_event    = set_evt;
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_tick.valid && i_tick.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (i_tick.valid && i_tick.ready) begin
            r_in <= i_tick.data;
        end
    end

    // Output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Supervisor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIN_COUNT; i++) begin
                r_cnt[i] <= '0;
            end
            r_temp_cnt <= '0;
            r_latch    <= '0;
            r_relay    <= 1'b0;
            r_lamp     <= 1'b0;
        end else if (advance) begin
            r_cnt      <= n_cnt;
            r_temp_cnt <= n_temp_cnt;
            r_latch    <= n_latch;
            r_relay    <= n_relay;
            r_lamp     <= n_lamp;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault_hold  <= HOLD_RESET;
            r_temp_hold   <= HOLD_RESET;
            r_remote_hold <= HOLD_RESET;
            r_key_hold    <= HOLD_RESET;
            r_temp_limit  <= LIMIT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.data.index)
                CFG_FAULT_HOLD: begin
                    r_fault_hold <= i_cfg.data.value;
                end
                CFG_TEMP_HOLD: begin
                    r_temp_hold <= i_cfg.data.value;
                end
                CFG_REMOTE_HOLD: begin
                    r_remote_hold <= i_cfg.data.value;
                end
                CFG_KEY_HOLD: begin
                    r_key_hold <= i_cfg.data.value;
                end
                CFG_TEMP_LIMIT: begin
                    r_temp_limit <= $signed(i_cfg.data.value[TEMP_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== src/hifs_checker.sv =====
// Port-level checks for the held-input fault supervisor, with the bind
// that attaches them. Depends on hifs_pkg and held_input_fault_supervisor.
module hifs_checker import hifs_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    tick_ready,
    input logic    cfg_ready,
    input logic    out_valid,
    input logic    out_ready,
    input t_result out_data
);

    // The result register is empty straight after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !out_valid)
        else $error("result valid straight after reset");

    // With the result register empty the block must take a tick word.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> tick_ready)
        else $error("tick channel stalled with empty output stage");

    // Configuration writes are never refused.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_ready)
        else $error("configuration channel not ready");

    // A stalled result word holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed under stall");

endmodule

bind held_input_fault_supervisor hifs_checker u_hifs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .tick_ready (i_tick.ready),
    .cfg_ready  (i_cfg.ready),
    .out_valid  (o_result.valid),
    .out_ready  (o_result.ready),
    .out_data   (o_result.data)
);
